// ----- design/assert_macros.svh -----
// assertion macros used by byte_ring_buffer_core
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that holds on every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// implication checked on every clock edge outside reset
`define ASSERT_IMPLY(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`endif

// ----- design/brb_pkg.sv -----
// shared types and constants for the byte ring buffer
// no dependencies
package brb_pkg;

    localparam int DEPTH    = 1024;
    localparam int MAX_LOG2 = $clog2(DEPTH);
    localparam int POS_W    = MAX_LOG2;
    localparam int IDX_W    = MAX_LOG2 + 1;
    localparam int CFG_W    = 4;

    typedef enum logic [2:0] {
        REQ_WRITE_BYTE = 3'd0,
        REQ_READ_BYTE  = 3'd1,
        REQ_COMMIT_RD  = 3'd2,
        REQ_COMMIT_WR  = 3'd3,
        REQ_READ_SEG   = 3'd4,
        REQ_WRITE_SEG  = 3'd5
    } req_t;

    typedef struct packed {
        logic             is_empty;
        logic             is_full;
        logic [IDX_W-1:0] fill_level;
        logic [POS_W-1:0] second_length;
        logic [IDX_W-1:0] first_length;
        logic [POS_W-1:0] first_offset;
        logic [1:0]       segment_count;
        logic [7:0]       read_data;
        logic [IDX_W-1:0] moved;
    } result_t;

endpackage

// ----- design/brb_ram.sv -----
// simple dual-port byte store, registered read
// no dependencies
module brb_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/byte_ring_buffer_core.sv -----
// byte ring buffer: index control, status and segment logic around the byte store
// depends on brb_pkg, brb_ram and assert_macros.svh
// one item per cycle unless the output stalls; a result goes through the byte store read stage, then the output reg
// a stalled output holds one item in the output reg and one in the byte store read stage
// reset clears both indices, sets capacity_log2 to 10 and drops pending items
// byte store contents are not cleared; a capacity write empties the buffer
`include "assert_macros.svh"

module byte_ring_buffer_core
    import brb_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,   // capacity_log2
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [23:0]      s_tdata,       // req_type, data_byte, count
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [71:0]      m_tdata        // moved, read_data, segment_count, first_offset,
                                            // first_length, second_length, fill_level,
                                            // is_full, is_empty
);

    logic [CFG_W-1:0] cap_log2_reg;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic             p1_valid_reg;
    logic             p1_rd_reg;
    result_t          p1_res_reg, p1_res_next;
    logic             m_valid_reg;
    result_t          m_res_reg, m_res_next;

    logic             accept;
    logic             advance;
    req_t             req;
    logic [7:0]       data_byte;
    logic [IDX_W-1:0] count;
    logic [CFG_W-1:0] cap_l;
    logic [IDX_W-1:0] cap;
    logic [POS_W-1:0] pmask;
    logic [IDX_W-1:0] fill, freeb, fill_after;
    logic [POS_W-1:0] rpos, wpos;
    logic             ram_wr_en, ram_rd_en;
    logic [7:0]       ram_rd_data;

    assign req       = req_t'(s_tdata[2:0]);
    assign data_byte = s_tdata[10:3];
    assign count     = s_tdata[21:11];

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !p1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    assign cap_l = (cap_log2_reg > CFG_W'(MAX_LOG2)) ? CFG_W'(MAX_LOG2) : cap_log2_reg;
    assign cap   = IDX_W'(1) << cap_l;
    assign pmask = POS_W'(cap - IDX_W'(1));
    assign fill  = wr_idx_reg - rd_idx_reg;
    assign freeb = (fill <= cap) ? cap - fill : '0;
    assign rpos  = rd_idx_reg[POS_W-1:0] & pmask;
    assign wpos  = wr_idx_reg[POS_W-1:0] & pmask;

    always_comb begin
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        p1_res_next = '0;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;
        unique case (req)
            REQ_WRITE_BYTE: begin
                if (freeb != '0) begin
                    ram_wr_en         = accept;
                    wr_idx_next       = wr_idx_reg + IDX_W'(1);
                    p1_res_next.moved = IDX_W'(1);
                end
            end
            REQ_READ_BYTE: begin
                if (fill != '0) begin
                    ram_rd_en         = accept;
                    rd_idx_next       = rd_idx_reg + IDX_W'(1);
                    p1_res_next.moved = IDX_W'(1);
                end
            end
            REQ_COMMIT_RD: begin
                p1_res_next.moved = (count < fill) ? count : fill;
                rd_idx_next       = rd_idx_reg + p1_res_next.moved;
            end
            REQ_COMMIT_WR: begin
                p1_res_next.moved = (count < freeb) ? count : freeb;
                wr_idx_next       = wr_idx_reg + p1_res_next.moved;
            end
            REQ_READ_SEG: begin
                if (fill != '0) begin
                    p1_res_next.first_offset = rpos;
                    if (wpos > rpos || wpos == '0) begin
                        p1_res_next.segment_count = 2'd1;
                        p1_res_next.first_length  = fill;
                    end else begin
                        p1_res_next.segment_count = 2'd2;
                        p1_res_next.first_length  = cap - {1'b0, rpos};
                        p1_res_next.second_length = wpos;
                    end
                end
            end
            REQ_WRITE_SEG: begin
                if (freeb != '0) begin
                    p1_res_next.first_offset = wpos;
                    if (rpos > wpos || rpos == '0) begin
                        p1_res_next.segment_count = 2'd1;
                        p1_res_next.first_length  = freeb;
                    end else begin
                        p1_res_next.segment_count = 2'd2;
                        p1_res_next.first_length  = cap - {1'b0, wpos};
                        p1_res_next.second_length = rpos;
                    end
                end
            end
            default: begin
            end
        endcase
        fill_after             = wr_idx_next - rd_idx_next;
        p1_res_next.fill_level = fill_after;
        p1_res_next.is_full    = (fill_after == cap);
        p1_res_next.is_empty   = (fill_after == '0);
    end

    brb_ram #(
        .ADDR_W (POS_W),
        .DATA_W (8)
    ) u_brb_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (wpos),
        .wr_data (data_byte),
        .rd_en   (ram_rd_en),
        .rd_addr (rpos),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_log2_reg <= CFG_W'(MAX_LOG2);
            rd_idx_reg   <= '0;
            wr_idx_reg   <= '0;
        end else if (cfg_wr_en) begin
            cap_log2_reg <= cfg_wr_data;
            rd_idx_reg   <= '0;
            wr_idx_reg   <= '0;
        end else if (accept) begin
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                p1_valid_reg <= 1'b1;
            end else if (advance) begin
                p1_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= p1_valid_reg;
            end
        end
    end

    always_comb begin
        m_res_next           = p1_res_reg;
        m_res_next.read_data = p1_rd_reg ? ram_rd_data : 8'd0;
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_res_reg <= p1_res_next;
            p1_rd_reg  <= ram_rd_en;
        end
        if (advance && p1_valid_reg) begin
            m_res_reg <= m_res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_res_reg};

    `ASSERT_ALWAYS(a_fill_in_range, (wr_idx_reg - rd_idx_reg) <= cap,
        "fill exceeds capacity")
    `ASSERT_IMPLY(a_p1_holds, (p1_valid_reg && !advance) |=> p1_valid_reg,
        "stalled item lost from read stage")
    `ASSERT_ALWAYS(a_flags_excl, !(m_valid_reg && m_res_reg.is_full && m_res_reg.is_empty),
        "result both full and empty")
    `ASSERT_IMPLY(a_rd_only_nonempty, ram_rd_en |-> (wr_idx_reg != rd_idx_reg),
        "byte read from empty buffer")

endmodule
